FILE: design/assert_macros.svh
// assertion macros shared by the lexer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define CTLEX_ASSERT(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define CTLEX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CTLEX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ctlex_pkg.sv
// types, constants and helper functions of the config text lexer
package ctlex_pkg;

	localparam int POS_BITS = 24;
	localparam int NUM_SLOTS = 3;
	localparam int CNT_BITS = $clog2(NUM_SLOTS + 1);
	localparam int SEL_BITS = $clog2(NUM_SLOTS);

	typedef logic [POS_BITS-1:0] pos_t;

	localparam pos_t POS_MAX = '1;
	localparam pos_t POS_ONE = POS_BITS'(1);
	localparam pos_t TAB_STOP = POS_BITS'(4);

	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_EQUAL = 8'h3d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;

	typedef enum logic [2:0] {
		MODE_EXPECT_ID,
		MODE_EXPECT_VALUE,
		MODE_AFTER_ID,
		MODE_AFTER_VALUE,
		MODE_AFTER_SEP,
		MODE_BLOCK_OPEN,
		MODE_BLOCK_CLOSE
	} mode_t;

	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_IDENT,
		PEND_NUMBER,
		PEND_STRING
	} pend_t;

	typedef enum logic [2:0] {
		KIND_IDENT,
		KIND_NUMBER,
		KIND_STRING,
		KIND_OPEN,
		KIND_CLOSE,
		KIND_ERROR,
		KIND_END
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_IDENT_START,
		ERR_VALUE,
		ERR_SYNTAX,
		ERR_UNTERMINATED
	} err_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		kind_t item_kind;
		err_t  err_code;
		pos_t  start_index;
		pos_t  token_length;
		pos_t  line_number;
		pos_t  column_number;
		logic  run_last;
	} token_item_t;

	typedef struct packed {
		token_item_t [NUM_SLOTS-1:0] item;
		logic [CNT_BITS-1:0]         count;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic is_ident(logic [7:0] b);
		return b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], CH_UNDERSCORE};
	endfunction

	function automatic logic is_value_start(logic [7:0] b);
		return b inside {[8'h30:8'h39], CH_MINUS, CH_QUOTE};
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b inside {CH_SPACE, CH_TAB, CH_NEWLINE};
	endfunction

	function automatic pos_t sat_add(pos_t a, pos_t b);
		logic [POS_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
	endfunction

	function automatic pos_t sat_inc(pos_t a);
		return (a == POS_MAX) ? POS_MAX : a + POS_ONE;
	endfunction

	function automatic token_item_t make_token(kind_t kind, err_t code, pos_t start,
		pos_t len, pos_t line, pos_t col);
		token_item_t t;
		t.item_kind = kind;
		t.err_code = code;
		t.start_index = start;
		t.token_length = len;
		t.line_number = line;
		t.column_number = col;
		t.run_last = 1'b0;
		return t;
	endfunction

endpackage

FILE: design/config_text_lexer.sv
// top level of the config text lexer: front, bundle queue and back
// a byte's result items are registered first in the bundle queue and then in the back output register
// throughput: one byte per cycle while each byte yields at most one result item and token_ready is not held low
// a byte that yields several result items holds the back serializer until each of them is handed out
// reset: arst_n clears lexer state, counters, queue pointers and output valid at once
module config_text_lexer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_ready,
	input  ctlex_pkg::text_item_t  text_item,
	output logic                   token_valid,
	input  logic                   token_ready,
	output ctlex_pkg::token_item_t token_item
);
	import ctlex_pkg::*;

	q_status_t q_status;
	bundle_t push_bundle, head;
	logic push, pop;

	ctlex_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text_item   (text_item),
		.q_status    (q_status),
		.push        (push),
		.push_bundle (push_bundle)
	);

	ctlex_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.pop         (pop),
		.head        (head),
		.status      (q_status)
	);

	ctlex_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_item  (token_item)
	);

endmodule

FILE: design/ctlex_front.sv
// lexer front: takes bytes, updates lexer state and positions, builds result bundles
`include "assert_macros.svh"

module ctlex_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_ready,
	input  ctlex_pkg::text_item_t  text_item,
	input  ctlex_pkg::q_status_t   q_status,
	output logic                   push,
	output ctlex_pkg::bundle_t     push_bundle
);
	import ctlex_pkg::*;

	mode_t mode_q, mode_n;
	pend_t pend_q, pend_n;
	pos_t  pstart_q, pstart_n;
	pos_t  plen_q, plen_n;
	pos_t  pline_q, pline_n;
	pos_t  pcol_q, pcol_n;
	pos_t  idx_q, line_q, col_q;
	pos_t  idx_adv, line_adv, col_adv;
	pos_t  col_m1, tab_step;
	logic  err_q, err_n;

	logic [7:0] b;
	logic last, acc, in_str;
	logic cont, go0, go1, go2;
	token_item_t slot0, slot1, slot2;
	logic slot0_v, slot1_v, slot2_v;
	logic [CNT_BITS-1:0] cnt;

	assign b = text_item.text_byte;
	assign last = text_item.end_of_text;
	assign text_ready = !q_status.full;
	assign acc = text_valid && text_ready;
	assign in_str = !err_q && (pend_q == PEND_STRING);

	// position advance
	always_comb begin
		col_m1 = col_q - POS_ONE;
		tab_step = (col_q == '0) ? TAB_STOP :
			TAB_STOP - {{(POS_BITS-2){1'b0}}, col_m1[1:0]};
		idx_adv = sat_inc(idx_q);
		line_adv = line_q;
		col_adv = sat_inc(col_q);
		if (!in_str && b == CH_NEWLINE) begin
			line_adv = sat_inc(line_q);
			col_adv = POS_ONE;
		end else if (!in_str && b == CH_TAB) begin
			col_adv = sat_add(col_q, tab_step);
		end
	end

	// lexer next state and emitted tokens
	always_comb begin
		mode_n = mode_q;
		pend_n = pend_q;
		pstart_n = pstart_q;
		plen_n = plen_q;
		pline_n = pline_q;
		pcol_n = pcol_q;
		err_n = err_q;
		cont = 1'b0;
		go0 = 1'b0;
		go1 = 1'b0;
		go2 = 1'b0;
		slot0 = make_token(KIND_IDENT, ERR_NONE, pstart_q, plen_q, pline_q, pcol_q);
		slot0_v = 1'b0;
		slot1 = make_token(KIND_OPEN, ERR_NONE, idx_q, '0, line_q, col_q);
		slot1_v = 1'b0;
		slot2 = make_token(KIND_END, ERR_NONE, idx_adv, '0, line_adv, col_adv);
		slot2_v = last;

		if (!err_q) begin
			case (pend_q)
				PEND_STRING: begin
					if (b == CH_QUOTE) begin
						pend_n = PEND_NONE;
						slot0 = make_token(KIND_STRING, ERR_NONE, pstart_q, plen_q, pline_q,
							pcol_q);
						slot0_v = (plen_q != '0);
					end else begin
						plen_n = sat_inc(plen_q);
					end
				end
				PEND_IDENT: begin
					if (is_ident(b)) begin
						plen_n = sat_inc(plen_q);
					end else begin
						slot0_v = 1'b1;
						pend_n = PEND_NONE;
						cont = 1'b1;
					end
				end
				PEND_NUMBER: begin
					if (!is_space(b) && b != CH_COMMA && b != CH_RBRACE) begin
						plen_n = sat_inc(plen_q);
					end else begin
						slot0 = make_token(KIND_NUMBER, ERR_NONE, pstart_q, plen_q, pline_q,
							pcol_q);
						slot0_v = 1'b1;
						pend_n = PEND_NONE;
						cont = 1'b1;
					end
				end
				default: cont = 1'b1;
			endcase

			if (cont && !is_space(b)) begin
				case (mode_q)
					MODE_EXPECT_ID: go0 = 1'b1;
					MODE_EXPECT_VALUE: go1 = 1'b1;
					MODE_AFTER_ID: go2 = 1'b1;
					MODE_AFTER_VALUE: begin
						if (b == CH_COMMA) begin
							mode_n = MODE_AFTER_SEP;
						end else if (b == CH_RBRACE) begin
							slot1 = make_token(KIND_CLOSE, ERR_NONE, idx_q, '0, line_q, col_q);
							slot1_v = 1'b1;
							mode_n = MODE_BLOCK_CLOSE;
						end else begin
							go0 = 1'b1;
						end
					end
					MODE_AFTER_SEP: begin
						if (b == CH_RBRACE) begin
							mode_n = MODE_BLOCK_CLOSE;
						end else if (is_value_start(b)) begin
							go1 = 1'b1;
						end else begin
							go0 = 1'b1;
						end
					end
					MODE_BLOCK_OPEN: begin
						if (is_value_start(b)) begin
							go1 = 1'b1;
						end else begin
							go0 = 1'b1;
						end
					end
					MODE_BLOCK_CLOSE: begin
						if (b == CH_COMMA) begin
							mode_n = MODE_AFTER_SEP;
						end else begin
							go0 = 1'b1;
						end
					end
					default: go0 = 1'b1;
				endcase

				if (go0) begin
					if (is_value_start(b)) begin
						slot1 = make_token(KIND_ERROR, ERR_IDENT_START, idx_q, '0, line_q, col_q);
						slot1_v = 1'b1;
						err_n = 1'b1;
						pend_n = PEND_NONE;
					end else begin
						mode_n = MODE_AFTER_ID;
						if (is_ident(b)) begin
							pend_n = PEND_IDENT;
							pstart_n = idx_q;
							pline_n = line_q;
							pcol_n = col_q;
							plen_n = POS_ONE;
						end else begin
							slot0 = make_token(KIND_IDENT, ERR_NONE, idx_q, '0, line_q, col_q);
							slot0_v = 1'b1;
							go2 = 1'b1;
						end
					end
				end

				if (go2) begin
					if (b == CH_EQUAL) begin
						mode_n = MODE_EXPECT_VALUE;
					end else if (b == CH_LBRACE) begin
						slot1 = make_token(KIND_OPEN, ERR_NONE, idx_q, '0, line_q, col_q);
						slot1_v = 1'b1;
						mode_n = MODE_BLOCK_OPEN;
					end else begin
						slot1 = make_token(KIND_ERROR, ERR_SYNTAX, idx_q, '0, line_q, col_q);
						slot1_v = 1'b1;
						err_n = 1'b1;
						pend_n = PEND_NONE;
					end
				end

				if (go1) begin
					if (b == CH_LBRACE) begin
						slot1 = make_token(KIND_OPEN, ERR_NONE, idx_q, '0, line_q, col_q);
						slot1_v = 1'b1;
						mode_n = MODE_BLOCK_OPEN;
					end else if (b == CH_QUOTE) begin
						pend_n = PEND_STRING;
						pstart_n = sat_inc(idx_q);
						pline_n = line_q;
						pcol_n = sat_inc(col_q);
						plen_n = '0;
						mode_n = MODE_AFTER_VALUE;
					end else if (is_value_start(b)) begin
						pend_n = PEND_NUMBER;
						pstart_n = idx_q;
						pline_n = line_q;
						pcol_n = col_q;
						plen_n = POS_ONE;
						mode_n = MODE_AFTER_VALUE;
					end else begin
						slot1 = make_token(KIND_ERROR, ERR_VALUE, idx_q, '0, line_q, col_q);
						slot1_v = 1'b1;
						err_n = 1'b1;
						pend_n = PEND_NONE;
					end
				end
			end
		end

		// end of text closes what is still open, unless an error has been flagged
		if (last && !err_n) begin
			if (pend_n == PEND_STRING) begin
				slot1 = make_token(KIND_ERROR, ERR_UNTERMINATED, pstart_n, '0, pline_n, pcol_n);
				slot1_v = 1'b1;
			end else if (pend_n != PEND_NONE) begin
				slot1 = make_token((pend_n == PEND_IDENT) ? KIND_IDENT : KIND_NUMBER, ERR_NONE,
					pstart_n, plen_n, pline_n, pcol_n);
				slot1_v = 1'b1;
			end
		end
	end

	// pack valid slots in order
	always_comb begin
		cnt = CNT_BITS'(slot0_v) + CNT_BITS'(slot1_v) + CNT_BITS'(slot2_v);
		push_bundle.item[0] = slot0_v ? slot0 : (slot1_v ? slot1 : slot2);
		push_bundle.item[1] = (slot0_v && slot1_v) ? slot1 : slot2;
		push_bundle.item[2] = slot2;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			push_bundle.item[i].run_last = (CNT_BITS'(i + 1) == cnt);
		end
		push_bundle.count = cnt;
	end

	assign push = acc && (cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EXPECT_ID;
			pend_q <= PEND_NONE;
			pstart_q <= '0;
			plen_q <= '0;
			pline_q <= POS_ONE;
			pcol_q <= POS_ONE;
			idx_q <= '0;
			line_q <= POS_ONE;
			col_q <= POS_ONE;
			err_q <= 1'b0;
		end else if (acc) begin
			if (last) begin
				mode_q <= MODE_EXPECT_ID;
				pend_q <= PEND_NONE;
				pstart_q <= '0;
				plen_q <= '0;
				pline_q <= POS_ONE;
				pcol_q <= POS_ONE;
				idx_q <= '0;
				line_q <= POS_ONE;
				col_q <= POS_ONE;
				err_q <= 1'b0;
			end else begin
				mode_q <= mode_n;
				pend_q <= pend_n;
				pstart_q <= pstart_n;
				plen_q <= plen_n;
				pline_q <= pline_n;
				pcol_q <= pcol_n;
				idx_q <= idx_adv;
				line_q <= line_adv;
				col_q <= col_adv;
				err_q <= err_n;
			end
		end
	end

	`CTLEX_ASSERT_IMPL(a_push_not_full, clk, arst_n, push, !q_status.full, "push into full queue")
	`CTLEX_ASSERT_NEXT(a_reset_after_last, clk, arst_n, acc && last, mode_q == MODE_EXPECT_ID && idx_q == '0 && !err_q && pend_q == PEND_NONE, "state not cleared after final byte")

endmodule

FILE: design/ctlex_queue.sv
// two-entry queue of result bundles between front and back
`include "assert_macros.svh"

module ctlex_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ctlex_pkg::bundle_t   push_bundle,
	input  logic                 pop,
	output ctlex_pkg::bundle_t   head,
	output ctlex_pkg::q_status_t status
);
	import ctlex_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int QCNT_BITS = $clog2(DEPTH + 1);

	bundle_t entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign head = entry_q[rd_ptr_q];
	assign status.full = (count_q == QCNT_BITS'(DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

	`CTLEX_ASSERT(a_count_bound, clk, arst_n, count_q <= QCNT_BITS'(DEPTH), "queue count out of range")
	`CTLEX_ASSERT_IMPL(a_pop_not_empty, clk, arst_n, pop, !status.empty, "pop from empty queue")

endmodule

FILE: design/ctlex_back.sv
// lexer back: walks each bundle and hands out one result item per cycle while token_ready is high
`include "assert_macros.svh"

module ctlex_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctlex_pkg::bundle_t     head,
	input  ctlex_pkg::q_status_t   q_status,
	output logic                   pop,
	output logic                   token_valid,
	input  logic                   token_ready,
	output ctlex_pkg::token_item_t token_item
);
	import ctlex_pkg::*;

	logic [SEL_BITS-1:0] pos_q;
	logic valid_q;
	token_item_t item_q;
	token_item_t cur;
	logic load, head_last;

	assign load = !q_status.empty && (!valid_q || token_ready);
	assign head_last = ((CNT_BITS'(pos_q) + CNT_BITS'(1)) == head.count);
	assign pop = load && head_last;

	always_comb begin
		cur = head.item[0];
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (SEL_BITS'(i) == pos_q) begin
				cur = head.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				pos_q <= head_last ? '0 : pos_q + SEL_BITS'(1);
			end else if (token_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= cur;
		end
	end

	assign token_valid = valid_q;
	assign token_item = item_q;

	`CTLEX_ASSERT_IMPL(a_pos_in_bundle, clk, arst_n, !q_status.empty, CNT_BITS'(pos_q) < head.count, "slot pointer past bundle count")

endmodule

FILE: tb/config_text_lexer_tb.sv
// testbench for config_text_lexer: directed text table and random config text checked against a token predictor
module config_text_lexer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ctlex_pkg::*;

	typedef enum int {PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE} phase_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eot;
		logic       has_exp;
		kind_t      kind;
		err_t       code;
		pos_t       start;
		pos_t       len;
		pos_t       line;
		pos_t       col;
	} plan_row_t;

	typedef struct {
		text_item_t  item;
		logic        has_exp;
		token_item_t exp;
	} stim_row_t;

	localparam int NPLAN = 30;
	localparam int RANDOM_BYTES = 150;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRESSURE_HOLD = 300;
	localparam int TAIL_CYCLES = 8;

	localparam plan_row_t PLAN [NPLAN] = '{
		'{"9", 1'b0, 1'b1, KIND_ERROR, ERR_IDENT_START, 0, 0, 1, 1},
		'{8'hff, 1'b1, 1'b1, KIND_END, ERR_NONE, 2, 0, 1, 3},
		'{"a", 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{"b", 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_LBRACE, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{"x", 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_EQUAL, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_QUOTE, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{"q", 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_QUOTE, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_COMMA, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_RBRACE, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_TAB, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_NEWLINE, 1'b1, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_EQUAL, 1'b0, 1'b1, KIND_IDENT, ERR_NONE, 0, 0, 1, 1},
		'{CH_QUOTE, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_QUOTE, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_COMMA, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{"5", 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{"0", 1'b1, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_EQUAL, 1'b0, 1'b1, KIND_IDENT, ERR_NONE, 0, 0, 1, 1},
		'{CH_RBRACE, 1'b0, 1'b1, KIND_ERROR, ERR_VALUE, 1, 0, 1, 2},
		'{8'h00, 1'b1, 1'b1, KIND_END, ERR_NONE, 3, 0, 1, 4},
		'{"z", 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{8'h00, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_QUOTE, 1'b1, 1'b1, KIND_END, ERR_NONE, 3, 0, 1, 4},
		'{"k", 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_EQUAL, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{CH_QUOTE, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0},
		'{8'h00, 1'b1, 1'b0, KIND_IDENT, ERR_NONE, 0, 0, 0, 0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_ready;
	text_item_t text_item = '0;
	logic token_valid;
	logic token_ready = 1'b0;
	token_item_t token_item;
	phase_t phase = PH_STEADY;

	mode_t lx_mode;
	pend_t pd_kind;
	pos_t pd_start, pd_len, pd_line, pd_col;
	pos_t lx_idx, lx_line, lx_col;
	logic lx_err;

	token_item_t byte_tokens[$];
	token_item_t expected_tokens[$];
	stim_row_t stim[$];
	logic [7:0] text_buf[$];

	int n_acc = 0;
	int fail_cnt = 0;
	int cycle_cnt = 0;
	int hold_left = 0;
	logic held = 1'b0;

	config_text_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_item(text_item),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_item(token_item)
	);

	always #6 clk = ~clk;

	function automatic pos_t clamp_add(pos_t a, pos_t b);
		return (a > POS_MAX - b) ? POS_MAX : a + b;
	endfunction

	function automatic logic is_name_char(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
			|| c == CH_UNDERSCORE;
	endfunction

	function automatic logic is_value_lead(logic [7:0] c);
		return (c >= "0" && c <= "9") || c == CH_MINUS || c == CH_QUOTE;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;
	endfunction

	task automatic clear_lexer();
		lx_mode = MODE_EXPECT_ID;
		pd_kind = PEND_NONE;
		pd_start = '0;
		pd_len = '0;
		pd_line = POS_ONE;
		pd_col = POS_ONE;
		lx_idx = '0;
		lx_line = POS_ONE;
		lx_col = POS_ONE;
		lx_err = 1'b0;
	endtask

	task automatic push_tok(kind_t kind, err_t code, pos_t start, pos_t len, pos_t line, pos_t col);
		token_item_t t;
		t.item_kind = kind;
		t.err_code = code;
		t.start_index = start;
		t.token_length = len;
		t.line_number = line;
		t.column_number = col;
		t.run_last = 1'b0;
		if (byte_tokens.size() < NUM_SLOTS) byte_tokens.push_back(t);
	endtask

	task automatic push_here(kind_t kind, err_t code);
		push_tok(kind, code, lx_idx, '0, lx_line, lx_col);
	endtask

	task automatic flag_error(err_t code);
		push_here(KIND_ERROR, code);
		lx_err = 1'b1;
		pd_kind = PEND_NONE;
	endtask

	task automatic close_pend();
		push_tok((pd_kind == PEND_IDENT) ? KIND_IDENT : KIND_NUMBER, ERR_NONE,
			pd_start, pd_len, pd_line, pd_col);
		pd_kind = PEND_NONE;
	endtask

	task automatic open_pend(pend_t kind, pos_t len);
		pd_kind = kind;
		pd_start = lx_idx;
		pd_line = lx_line;
		pd_col = lx_col;
		pd_len = len;
	endtask

	task automatic lex_byte(input logic [7:0] b, output logic in_str);
		logic done;
		int g;
		in_str = 1'b0;
		done = 1'b0;
		if (pd_kind == PEND_STRING) begin
			if (b == CH_QUOTE) begin
				if (pd_len != 0) push_tok(KIND_STRING, ERR_NONE, pd_start, pd_len, pd_line, pd_col);
				pd_kind = PEND_NONE;
			end else begin
				pd_len = clamp_add(pd_len, POS_ONE);
			end
			in_str = 1'b1;
			done = 1'b1;
		end else if (pd_kind == PEND_IDENT) begin
			if (is_name_char(b)) begin
				pd_len = clamp_add(pd_len, POS_ONE);
				done = 1'b1;
			end else begin
				close_pend();
			end
		end else if (pd_kind == PEND_NUMBER) begin
			if (!is_blank(b) && b != CH_COMMA && b != CH_RBRACE) begin
				pd_len = clamp_add(pd_len, POS_ONE);
				done = 1'b1;
			end else begin
				close_pend();
			end
		end
		if (!done && is_blank(b)) done = 1'b1;
		for (g = 0; g < 8 && !done; g++) begin
			case (lx_mode)
				MODE_EXPECT_ID: begin
					if (is_value_lead(b)) begin
						flag_error(ERR_IDENT_START);
						done = 1'b1;
					end else begin
						lx_mode = MODE_AFTER_ID;
						if (is_name_char(b)) begin
							open_pend(PEND_IDENT, POS_ONE);
							done = 1'b1;
						end else begin
							push_here(KIND_IDENT, ERR_NONE);
						end
					end
				end
				MODE_EXPECT_VALUE: begin
					done = 1'b1;
					if (b == CH_LBRACE) begin
						push_here(KIND_OPEN, ERR_NONE);
						lx_mode = MODE_BLOCK_OPEN;
					end else if (b == CH_QUOTE) begin
						open_pend(PEND_STRING, '0);
						pd_start = clamp_add(lx_idx, POS_ONE);
						pd_col = clamp_add(lx_col, POS_ONE);
						lx_mode = MODE_AFTER_VALUE;
					end else if (is_value_lead(b)) begin
						open_pend(PEND_NUMBER, POS_ONE);
						lx_mode = MODE_AFTER_VALUE;
					end else begin
						flag_error(ERR_VALUE);
					end
				end
				MODE_AFTER_ID: begin
					if (b == CH_EQUAL) begin
						lx_mode = MODE_EXPECT_VALUE;
						done = 1'b1;
					end else if (b != CH_LBRACE) begin
						flag_error(ERR_SYNTAX);
						done = 1'b1;
					end else begin
						lx_mode = MODE_EXPECT_VALUE;
					end
				end
				MODE_AFTER_VALUE: begin
					if (b == CH_COMMA) begin
						lx_mode = MODE_AFTER_SEP;
						done = 1'b1;
					end else if (b == CH_RBRACE) begin
						push_here(KIND_CLOSE, ERR_NONE);
						lx_mode = MODE_BLOCK_CLOSE;
						done = 1'b1;
					end else begin
						lx_mode = MODE_EXPECT_ID;
					end
				end
				MODE_AFTER_SEP: begin
					if (b == CH_RBRACE) begin
						lx_mode = MODE_BLOCK_CLOSE;
						done = 1'b1;
					end else begin
						lx_mode = is_value_lead(b) ? MODE_EXPECT_VALUE : MODE_EXPECT_ID;
					end
				end
				MODE_BLOCK_OPEN: lx_mode = is_value_lead(b) ? MODE_EXPECT_VALUE : MODE_EXPECT_ID;
				MODE_BLOCK_CLOSE: begin
					if (b == CH_COMMA) begin
						lx_mode = MODE_AFTER_SEP;
						done = 1'b1;
					end else begin
						lx_mode = MODE_EXPECT_ID;
					end
				end
				default: lx_mode = MODE_EXPECT_ID;
			endcase
		end
	endtask

	task automatic predict_tokens(input text_item_t it);
		logic in_str;
		pos_t c;
		byte_tokens.delete();
		in_str = 1'b0;
		if (!lx_err) lex_byte(it.text_byte, in_str);
		lx_idx = clamp_add(lx_idx, POS_ONE);
		if (!in_str && it.text_byte == CH_NEWLINE) begin
			lx_line = clamp_add(lx_line, POS_ONE);
			lx_col = POS_ONE;
		end else if (!in_str && it.text_byte == CH_TAB) begin
			c = (lx_col == 0) ? '0 : lx_col - POS_ONE;
			lx_col = clamp_add(lx_col, TAB_STOP - (c % TAB_STOP));
		end else begin
			lx_col = clamp_add(lx_col, POS_ONE);
		end
		if (it.end_of_text) begin
			if (!lx_err) begin
				if (pd_kind == PEND_STRING)
					push_tok(KIND_ERROR, ERR_UNTERMINATED, pd_start, '0, pd_line, pd_col);
				else if (pd_kind != PEND_NONE)
					close_pend();
			end
			push_here(KIND_END, ERR_NONE);
			clear_lexer();
		end
		if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].run_last = 1'b1;
	endtask

	function automatic logic [7:0] rand_name_char(bit lead);
		int r;
		r = $urandom_range(0, lead ? 52 : 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return CH_UNDERSCORE;
		return 8'("0" + r - 53);
	endfunction

	task automatic put_blank(input int min_n);
		int n, k;
		n = min_n + (($urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : 0);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 2))
				0: text_buf.push_back(CH_SPACE);
				1: text_buf.push_back(CH_TAB);
				default: text_buf.push_back(CH_NEWLINE);
			endcase
		end
	endtask

	task automatic put_ident();
		int n, k;
		n = $urandom_range(1, 4);
		text_buf.push_back(rand_name_char(1'b1));
		for (k = 1; k < n; k++) text_buf.push_back(rand_name_char(1'b0));
	endtask

	task automatic put_scalar();
		int n, k;
		logic [7:0] c;
		n = $urandom_range(0, 3);
		if ($urandom_range(0, 1) == 0) begin
			text_buf.push_back(($urandom_range(0, 3) == 0) ? CH_MINUS : 8'("0" + $urandom_range(0, 9)));
			for (k = 0; k < n; k++) text_buf.push_back(rand_name_char(1'b0));
		end else begin
			text_buf.push_back(CH_QUOTE);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 7) == 0) begin
					c = $urandom_range(0, 1) ? CH_TAB : CH_NEWLINE;
				end else begin
					c = 8'($urandom_range(8'h20, 8'h7e));
					if (c == CH_QUOTE) c = "Q";
				end
				text_buf.push_back(c);
			end
			text_buf.push_back(CH_QUOTE);
		end
	endtask

	task automatic put_value();
		int n, k;
		if ($urandom_range(0, 4) == 0) begin
			text_buf.push_back(CH_LBRACE);
			put_blank(0);
			n = $urandom_range(1, 3);
			for (k = 0; k < n; k++) begin
				if (k > 0) begin
					text_buf.push_back(CH_COMMA);
					put_blank(0);
				end
				put_scalar();
				put_blank(0);
			end
			if ($urandom_range(0, 3) == 0) text_buf.push_back(CH_COMMA);
			put_blank(0);
			text_buf.push_back(CH_RBRACE);
		end else begin
			put_scalar();
		end
	endtask

	task automatic put_statement();
		int n, k;
		put_ident();
		put_blank(0);
		if ($urandom_range(0, 3) == 0) begin
			text_buf.push_back(CH_LBRACE);
			put_blank(0);
			n = $urandom_range(1, 2);
			for (k = 0; k < n; k++) begin
				put_ident();
				put_blank(0);
				text_buf.push_back(CH_EQUAL);
				put_blank(0);
				put_scalar();
				put_blank(1);
			end
			text_buf.push_back(CH_RBRACE);
		end else begin
			text_buf.push_back(CH_EQUAL);
			put_blank(0);
			put_value();
		end
		put_blank(1);
	endtask

	task automatic put_doc();
		int n, k, keep;
		stim_row_t r;
		text_buf.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++) text_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 4);
			for (k = 0; k < n; k++) put_statement();
			if ($urandom_range(0, 4) == 0)
				text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) == 0) begin
				keep = $urandom_range(1, text_buf.size());
				while (text_buf.size() > keep) void'(text_buf.pop_back());
			end
		end
		for (k = 0; k < text_buf.size(); k++) begin
			r.item.text_byte = text_buf[k];
			r.item.end_of_text = (k == text_buf.size() - 1);
			r.has_exp = 1'b0;
			r.exp = '0;
			stim.push_back(r);
		end
	endtask

	function automatic phase_t phase_at(int idx, int total);
		if (idx < NPLAN) return PH_STEADY;
		case ((idx - NPLAN) * 5 / (total - NPLAN))
			0: return PH_STEADY;
			1: return PH_SEND_IDLE;
			2: return PH_RECV_STALL;
			3: return PH_BOTH;
			default: return PH_PRESSURE;
		endcase
	endfunction

	function automatic int idle_pct(phase_t p, bit recv_side);
		if (p == PH_BOTH) return 22;
		if (p == (recv_side ? PH_RECV_STALL : PH_SEND_IDLE)) return 81;
		return 0;
	endfunction

	task automatic show_bad(input string what, input token_item_t want, input token_item_t got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%s: want kind=%0d code=%0d start=%0d len=%0d line=%0d col=%0d last=%0b",
				what, want.item_kind, want.err_code, want.start_index, want.token_length,
				want.line_number, want.column_number, want.run_last,
				"  got kind=%0d code=%0d start=%0d len=%0d line=%0d col=%0d last=%0b",
				got.item_kind, got.err_code, got.start_index, got.token_length,
				got.line_number, got.column_number, got.run_last);
	endtask

	always @(posedge clk) begin : check_tokens
		token_item_t want;
		stim_row_t row;
		if (arst_n) begin
			if (token_valid && token_ready) begin
				if (expected_tokens.size() == 0) begin
					show_bad("unexpected token item", '0, token_item);
				end else begin
					want = expected_tokens.pop_front();
					if (token_item !== want) show_bad("token item mismatch", want, token_item);
				end
			end
			if (text_valid && text_ready) begin
				predict_tokens(text_item);
				row = stim[n_acc];
				n_acc++;
				if (row.has_exp) expected_tokens.push_back(row.exp);
				else foreach (byte_tokens[k]) expected_tokens.push_back(byte_tokens[k]);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			token_ready <= 1'b0;
		end else if (phase == PH_PRESSURE && !held) begin
			hold_left <= PRESSURE_HOLD;
			held <= 1'b1;
			token_ready <= 1'b0;
		end else begin
			token_ready <= ($urandom_range(0, 99) >= idle_pct(phase, 1'b1));
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int idx, k;
		plan_row_t p;
		stim_row_t r;
		phase_t ph;
		clear_lexer();
		for (k = 0; k < NPLAN; k++) begin
			p = PLAN[k];
			r.item.text_byte = p.b;
			r.item.end_of_text = p.eot;
			r.has_exp = p.has_exp;
			r.exp = token_item_t'{p.kind, p.code, p.start, p.len, p.line, p.col, 1'b1};
			stim.push_back(r);
		end
		while (stim.size() < NPLAN + RANDOM_BYTES) put_doc();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		idx = 0;
		while (idx < stim.size()) begin
			@(posedge clk);
			if (text_valid && text_ready) idx++;
			else if (text_valid) continue;
			ph = phase_at(idx, stim.size());
			phase <= ph;
			if (idx < stim.size() && $urandom_range(0, 99) >= idle_pct(ph, 1'b0)) begin
				text_valid <= 1'b1;
				text_item <= stim[idx].item;
			end else begin
				text_valid <= 1'b0;
			end
		end

		@(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		fail_cnt += expected_tokens.size();
		if (fail_cnt == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: config_text_lexer.f
+incdir+design
design/ctlex_pkg.sv
design/ctlex_front.sv
design/ctlex_queue.sv
design/ctlex_back.sv
design/config_text_lexer.sv
tb/config_text_lexer_tb.sv
